[design/matrix_vector_multiply_add_macros.svh]
// assertion macros for the checker file of matrix_vector_multiply_add
// depends on a clk and an rst signal in the scope where a macro is used
`ifndef MATRIX_VECTOR_MULTIPLY_ADD_MACROS_SVH
`define MATRIX_VECTOR_MULTIPLY_ADD_MACROS_SVH

// property checked at every edge outside reset
`define MVA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define MVA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/mva_pkg.sv]
// shared constants for the matrix-vector multiply-add block
// used by matrix_vector_multiply_add and its checker, no dependencies
package mva_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int DATA_W = 32;
  localparam int PROD_W = 64;
  localparam int ACC_W  = 56;
  localparam int SUM_W  = ACC_W + 1;
  localparam int CFG_W  = 7;
  localparam int CFG_IDX_W = 1;

  localparam int FRAC_W = 16;

  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 40;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b1;

  // item kinds on the input tuser
  localparam logic MODE_LOAD_X  = 1'b0;
  localparam logic MODE_MATRIX  = 1'b1;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

endpackage

[design/matrix_vector_multiply_add.sv]
// matrix_vector_multiply_add: out = A*x + y in signed Q16.16, one row per result item
// depends on mva_pkg
// usage
//   s_axis carries x loads (tuser = 0, value at col_index is stored) and matrix
//   elements in row-major order (tuser = 1), each with y of its row in bias.
//   m_axis gives one item per row, at the item whose column is cols_in_use - 1:
//   row, dot product plus y saturated to 32 bits, tuser = saturated flag,
//   tlast = last row of the matrix.
//   cfg_we / cfg_index / cfg_data write rows_in_use and cols_in_use while idle.
// timing
//   one item accepted per cycle while s_axis_tready is high; a result passes the
//   x read, multiply, accumulate and saturate stages before it shows on m_axis.
//   the rate is set by the row accumulator, a 56-bit add that feeds its own register.
// reset
//   rst is synchronous: stages are emptied, the accumulator is cleared and both
//   counts return to 1. the x store is not cleared; load x before using it.
// backpressure
//   a result waiting on m_axis holds only the stages behind it that carry an
//   item; empty stages and items without result keep moving, so s_axis_tready
//   falls only once the pipeline behind a stalled result is full.
module matrix_vector_multiply_add #(
  parameter int MAX_ROWS = mva_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = mva_pkg::DEF_MAX_COLS
) (
  input  logic                            clk,
  input  logic                            rst,
  // tdata: row_index[5:0], col_index[11:6], value[43:12], bias[75:44], zeros above
  input  logic [mva_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // tuser: mode
  input  logic                            s_axis_tuser,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: out_row[5:0], out_value[37:6], zeros above
  output logic [mva_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // tuser: saturated
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_we,
  input  logic [mva_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mva_pkg::CFG_W-1:0]       cfg_data
);

  localparam int AW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_W = $clog2(MAX_ROWS + MAX_COLS + 128);

  // configuration
  logic [mva_pkg::CFG_W-1:0] rows_in_use;
  logic [mva_pkg::CFG_W-1:0] cols_in_use;
  logic [CNT_W-1:0]          row_last;
  logic [CNT_W-1:0]          col_last;

  // input fields
  logic [mva_pkg::ROW_W-1:0]         in_row;
  logic [mva_pkg::COL_W-1:0]         in_col;
  logic signed [mva_pkg::DATA_W-1:0] in_value;
  logic signed [mva_pkg::DATA_W-1:0] in_bias;
  logic                              in_accept;
  logic                              in_col_ok;
  logic [AW-1:0]                     x_addr;

  // x store
  logic signed [mva_pkg::DATA_W-1:0] x_vector [MAX_COLS];

  // stage 1: x read
  logic                              v1;
  logic                              mode1;
  logic                              col_ok1;
  logic [mva_pkg::ROW_W-1:0]         row1;
  logic [mva_pkg::COL_W-1:0]         col1;
  logic signed [mva_pkg::DATA_W-1:0] value1;
  logic signed [mva_pkg::DATA_W-1:0] bias1;
  logic signed [mva_pkg::DATA_W-1:0] x_rd;
  logic signed [mva_pkg::DATA_W-1:0] x_op;

  // stage 2: product
  logic                              v2;
  logic                              clr2;
  logic                              emit2;
  logic                              last2;
  logic [mva_pkg::ROW_W-1:0]         row2;
  logic signed [mva_pkg::DATA_W-1:0] bias2;
  logic signed [mva_pkg::PROD_W-1:0] prod2;

  // stage 3: accumulator
  logic                              v3;
  logic                              emit3;
  logic                              last3;
  logic [mva_pkg::ROW_W-1:0]         row3;
  logic signed [mva_pkg::DATA_W-1:0] bias3;
  logic signed [mva_pkg::ACC_W-1:0]  acc;
  logic signed [mva_pkg::ACC_W-1:0]  acc_next;
  logic signed [mva_pkg::SUM_W-1:0]  sum;

  // output register
  logic                              out_valid;
  logic [mva_pkg::ROW_W-1:0]         out_row;
  logic signed [mva_pkg::DATA_W-1:0] out_value;
  logic                              out_sat;
  logic                              out_last;

  logic out_free;
  logic ready1;
  logic ready2;
  logic ready3;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= mva_pkg::CFG_W'(1);
      cols_in_use <= mva_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mva_pkg::CFG_ROWS_IN_USE: rows_in_use <= cfg_data;
        mva_pkg::CFG_COLS_IN_USE: cols_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, counts above the store size act as the size
  always_comb begin
    if (rows_in_use == '0) begin
      row_last = '0;
    end else if (CNT_W'(rows_in_use) > CNT_W'(MAX_ROWS)) begin
      row_last = CNT_W'(MAX_ROWS - 1);
    end else begin
      row_last = CNT_W'(rows_in_use) - CNT_W'(1);
    end
    if (cols_in_use == '0) begin
      col_last = '0;
    end else if (CNT_W'(cols_in_use) > CNT_W'(MAX_COLS)) begin
      col_last = CNT_W'(MAX_COLS - 1);
    end else begin
      col_last = CNT_W'(cols_in_use) - CNT_W'(1);
    end
  end

  assign in_row    = s_axis_tdata[5:0];
  assign in_col    = s_axis_tdata[11:6];
  assign in_value  = s_axis_tdata[43:12];
  assign in_bias   = s_axis_tdata[75:44];
  assign in_col_ok = CNT_W'(in_col) < CNT_W'(MAX_COLS);
  assign x_addr    = AW'(in_col);

  // a stage moves on when it is empty or its item can leave
  assign out_free      = !out_valid || m_axis_tready;
  assign ready3        = !v3 || !emit3 || out_free;
  assign ready2        = !v2 || ready3;
  assign ready1        = !v1 || (mode1 == mva_pkg::MODE_LOAD_X) || ready2;
  assign s_axis_tready = ready1;
  assign in_accept     = s_axis_tvalid && ready1;

  // x store: written and read at the accept edge, so a load is seen by the next item
  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (s_axis_tuser == mva_pkg::MODE_LOAD_X && in_col_ok) begin
        x_vector[x_addr] <= in_value;
      end
      x_rd <= x_vector[x_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode1   <= s_axis_tuser;
      col_ok1 <= in_col_ok;
      row1    <= in_row;
      col1    <= in_col;
      value1  <= in_value;
      bias1   <= in_bias;
    end
  end

  // an index beyond the store reads as zero
  assign x_op = col_ok1 ? x_rd : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1 && (mode1 == mva_pkg::MODE_MATRIX);
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      prod2 <= value1 * x_op;
      clr2  <= (col1 == '0);
      emit2 <= (CNT_W'(col1) == col_last);
      last2 <= (CNT_W'(row1) == row_last);
      row2  <= row1;
      bias2 <= bias1;
    end
  end

  // floor shift of the Q32.32 product, wraps modulo 2^56
  always_comb begin
    acc_next = (clr2 ? '0 : acc)
             + {{(mva_pkg::ACC_W - (mva_pkg::PROD_W - mva_pkg::FRAC_W))
                 {prod2[mva_pkg::PROD_W-1]}},
                prod2[mva_pkg::PROD_W-1:mva_pkg::FRAC_W]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3  <= 1'b0;
      acc <= '0;
    end else if (ready3) begin
      v3 <= v2;
      if (v2) begin
        acc <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      emit3 <= emit2;
      last3 <= last2;
      row3  <= row2;
      bias3 <= bias2;
    end
  end

  assign sum = mva_pkg::SUM_W'(acc) + mva_pkg::SUM_W'(bias3);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= v3 && emit3;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && v3 && emit3) begin
      out_row  <= row3;
      out_last <= last3;
      if (sum > mva_pkg::SUM_W'(mva_pkg::Q_MAX)) begin
        out_value <= mva_pkg::Q_MAX;
        out_sat   <= 1'b1;
      end else if (sum < mva_pkg::SUM_W'(mva_pkg::Q_MIN)) begin
        out_value <= mva_pkg::Q_MIN;
        out_sat   <= 1'b1;
      end else begin
        out_value <= sum[mva_pkg::DATA_W-1:0];
        out_sat   <= 1'b0;
      end
    end
  end

  assign m_axis_tdata  = {{(mva_pkg::M_TDATA_W - mva_pkg::DATA_W - mva_pkg::ROW_W){1'b0}},
                          out_value, out_row};
  assign m_axis_tuser  = out_sat;
  assign m_axis_tlast  = out_last;
  assign m_axis_tvalid = out_valid;

endmodule

[design/mva_checker.sv]
// port-level checks for matrix_vector_multiply_add, attached by bind
// depends on mva_pkg and matrix_vector_multiply_add_macros.svh
`include "matrix_vector_multiply_add_macros.svh"

module mva_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tready,
  input logic [mva_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready
);

  // a held result keeps its payload
  `MVA_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

  // input stalls only behind a stalled result
  `MVA_ASSERT(a_ready_cause, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

  // a clamped result sits at one of the range limits
  `MVA_ASSERT(a_sat_value, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[37:6] == 32'h7fff_ffff || m_axis_tdata[37:6] == 32'h8000_0000, "saturated flag with value off the limits")

  // reset empties the output register
  `MVA_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind matrix_vector_multiply_add mva_checker u_mva_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
